// ----- hdl/gtg_pkg.sv -----
`default_nettype none
package gtg_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int IDX_W        = $clog2(ATAN_ENTRIES);
  localparam int ZW           = 32;
  localparam int DW           = COORD_WIDTH + 1;
  localparam int XW           = COORD_WIDTH + 3;
  localparam int RW           = COORD_WIDTH - 1;
  localparam int SPEED_W      = 16;
  localparam int CFG_IDX_W    = 3;

  localparam int IN_W   = 4 * COORD_WIDTH;
  localparam int OUT_RAW_W = SPEED_W + ANGLE_WIDTH + 1;
  localparam int OUT_W  = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN      = 3'd4;

  localparam logic [ANGLE_WIDTH-1:0] SPIN_RESET = ANGLE_WIDTH'(8192);

  localparam logic [ZW-1:0] Z_QUARTER       = 32'h4000_0000;
  localparam logic [ZW-1:0] Z_THREE_QUARTER = 32'hC000_0000;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    logic  valid;
    lane_t goal;
    lane_t head;
  } cell_t;

  function automatic logic [ZW-1:0] atan_at(input logic [IDX_W-1:0] i);
    logic [ZW-1:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/go_to_goal_steering.sv -----
`default_nettype none
// Go-to-goal steering: one drive command per pose beat. Bearings to the goal and
// of the heading vector come from a row of CORDIC vectoring cells, one cell per
// iteration, both vectors side by side; the squared-distance arrival test runs
// alongside in four stages. A new pose is taken every cycle while s_tready is
// high. A pose beat passes the difference stage, the quadrant stage, the cell
// row and the output register in that order. Backpressure stalls the whole row;
// a one-beat skid stage behind the output register keeps s_tready registered.
module go_to_goal_steering (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [gtg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [gtg_pkg::COORD_WIDTH-1:0]      cfg_data,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [gtg_pkg::IN_W-1:0]             s_tdata,   // pos_x, pos_y, head_x, head_y
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [gtg_pkg::OUT_W-1:0]                 m_tdata    // forward_speed, turn_angle, arrived
);

  localparam int CW  = gtg_pkg::COORD_WIDTH;
  localparam int AW  = gtg_pkg::ANGLE_WIDTH;
  localparam int NS  = gtg_pkg::CORDIC_STAGES;
  localparam int DLY = NS - 3;

  logic signed [CW-1:0]           goal_x, goal_y;
  logic [gtg_pkg::SPEED_W-1:0]    cruise_speed;
  logic [gtg_pkg::RW-1:0]         arrive_radius;
  logic [AW-1:0]                  spin_threshold;

  logic                           adv;
  logic                           v1;
  logic signed [gtg_pkg::DW-1:0]  dx1, dy1;
  logic signed [CW-1:0]           hx1, hy1;
  gtg_pkg::cell_t                 chain [0:NS];
  logic                           arr_r;
  logic [DLY-1:0]                 arr_dly;

  logic [gtg_pkg::ZW-1:0]         zg, zh;
  logic [AW-1:0]                  bg, bh, err, aerr;
  logic                           arr_e;
  logic [gtg_pkg::OUT_W-1:0]      e_data;
  logic                           skid_v;
  logic [gtg_pkg::OUT_W-1:0]      skid_data;

  assign adv      = ~skid_v;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x         <= '0;
      goal_y         <= '0;
      cruise_speed   <= '0;
      arrive_radius  <= '0;
      spin_threshold <= gtg_pkg::SPIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gtg_pkg::REG_GOAL_X: goal_x         <= cfg_data;
        gtg_pkg::REG_GOAL_Y: goal_y         <= cfg_data;
        gtg_pkg::REG_CRUISE: cruise_speed   <= cfg_data[gtg_pkg::SPEED_W-1:0];
        gtg_pkg::REG_RADIUS: arrive_radius  <= cfg_data[gtg_pkg::RW-1:0];
        gtg_pkg::REG_SPIN:   spin_threshold <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
    if (adv) begin
      dx1 <= gtg_pkg::DW'(goal_x) - gtg_pkg::DW'($signed(s_tdata[CW-1:0]));
      dy1 <= gtg_pkg::DW'(goal_y) - gtg_pkg::DW'($signed(s_tdata[2*CW-1:CW]));
      hx1 <= s_tdata[3*CW-1:2*CW];
      hy1 <= s_tdata[4*CW-1:3*CW];
    end
  end

  gtg_front u_front (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .valid(v1),
    .dx   (dx1),
    .dy   (dy1),
    .hx   (hx1),
    .hy   (hy1),
    .dout (chain[0])
  );

  gtg_range u_range (
    .clk    (clk),
    .adv    (adv),
    .dx     (dx1),
    .dy     (dy1),
    .radius (arrive_radius),
    .arrived(arr_r)
  );

  for (genvar k = 0; k < NS; k++) begin : g_cell
    gtg_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .stage(gtg_pkg::IDX_W'(k)),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      arr_dly <= {arr_dly[DLY-2:0], arr_r};
    end
  end

  always_comb begin
    zg    = chain[NS].goal.z + (gtg_pkg::ZW'(1) << (31 - AW));
    zh    = chain[NS].head.z + (gtg_pkg::ZW'(1) << (31 - AW));
    bg    = chain[NS].goal.zero ? '0 : zg[gtg_pkg::ZW-1 -: AW];
    bh    = chain[NS].head.zero ? '0 : zh[gtg_pkg::ZW-1 -: AW];
    err   = bg - bh;
    aerr  = err[AW-1] ? -err : err;
    arr_e = arr_dly[DLY-1];
    e_data = '0;
    if (!arr_e) begin
      e_data[gtg_pkg::SPEED_W-1:0] = (aerr > spin_threshold) ? '0 : cruise_speed;
      e_data[gtg_pkg::SPEED_W +: AW] = err;
    end
    e_data[gtg_pkg::SPEED_W + AW] = arr_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (adv && chain[NS].valid) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      m_tvalid <= 1'b1;
      skid_v   <= 1'b0;
    end else begin
      m_tvalid <= chain[NS].valid;
    end
    if (m_tvalid && !m_tready) begin
      if (adv) begin
        skid_data <= e_data;
      end
    end else if (skid_v) begin
      m_tdata <= skid_data;
    end else begin
      m_tdata <= e_data;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gtg_cell.sv -----
`default_nettype none
module gtg_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic [gtg_pkg::IDX_W-1:0]   stage,
  input  wire gtg_pkg::cell_t              din,
  output gtg_pkg::cell_t                   dout
);

  function automatic gtg_pkg::lane_t rotate(input gtg_pkg::lane_t l,
                                            input logic [gtg_pkg::IDX_W-1:0] i);
    gtg_pkg::lane_t r;
    logic signed [gtg_pkg::XW-1:0] xs;
    logic signed [gtg_pkg::XW-1:0] ys;
    r  = l;
    xs = l.x >>> i;
    ys = l.y >>> i;
    if (!l.y[gtg_pkg::XW-1]) begin
      r.x = l.x + ys;
      r.y = l.y - xs;
      r.z = l.z + gtg_pkg::atan_at(i);
    end else begin
      r.x = l.x - ys;
      r.y = l.y + xs;
      r.z = l.z - gtg_pkg::atan_at(i);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= din.valid;
    end
    if (adv) begin
      dout.goal <= rotate(din.goal, stage);
      dout.head <= rotate(din.head, stage);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gtg_front.sv -----
`default_nettype none
module gtg_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 adv,
  input  wire logic                                 valid,
  input  wire logic signed [gtg_pkg::DW-1:0]        dx,
  input  wire logic signed [gtg_pkg::DW-1:0]        dy,
  input  wire logic signed [gtg_pkg::COORD_WIDTH-1:0] hx,
  input  wire logic signed [gtg_pkg::COORD_WIDTH-1:0] hy,
  output gtg_pkg::cell_t                            dout
);

  function automatic gtg_pkg::lane_t prerot(input logic signed [gtg_pkg::XW-1:0] x,
                                            input logic signed [gtg_pkg::XW-1:0] y);
    gtg_pkg::lane_t r;
    r.zero = (x == '0) && (y == '0);
    r.x = x;
    r.y = y;
    r.z = '0;
    if (x[gtg_pkg::XW-1]) begin
      if (!y[gtg_pkg::XW-1]) begin
        r.x = y;
        r.y = -x;
        r.z = gtg_pkg::Z_QUARTER;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = gtg_pkg::Z_THREE_QUARTER;
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= valid;
    end
    if (adv) begin
      dout.goal <= prerot(gtg_pkg::XW'(dx), gtg_pkg::XW'(dy));
      dout.head <= prerot(gtg_pkg::XW'(hx), gtg_pkg::XW'(hy));
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gtg_range.sv -----
`default_nettype none
module gtg_range (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire logic signed [gtg_pkg::DW-1:0] dx,
  input  wire logic signed [gtg_pkg::DW-1:0] dy,
  input  wire logic [gtg_pkg::RW-1:0]        radius,
  output logic                               arrived
);

  localparam int D   = gtg_pkg::DW;
  localparam int L   = D / 2;
  localparam int H   = D - L;
  localparam int SQW = 2 * D;
  localparam int R   = gtg_pkg::RW;
  localparam int RL  = R / 2;
  localparam int RH  = R - RL;
  localparam int RSQ = 2 * R;

  logic [D-1:0]      ax, ay;
  logic [2*H-1:0]    xhh, yhh;
  logic [H+L-1:0]    xhl, yhl;
  logic [2*L-1:0]    xll, yll;
  logic [2*RH-1:0]   rhh;
  logic [RH+RL-1:0]  rhl;
  logic [2*RL-1:0]   rll;
  logic [SQW-1:0]    sqx, sqy;
  logic [RSQ-1:0]    sqr;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= dx[D-1] ? D'(-dx) : D'(dx);
      ay <= dy[D-1] ? D'(-dy) : D'(dy);

      xhh <= ax[D-1:L] * ax[D-1:L];
      xhl <= ax[D-1:L] * ax[L-1:0];
      xll <= ax[L-1:0] * ax[L-1:0];
      yhh <= ay[D-1:L] * ay[D-1:L];
      yhl <= ay[D-1:L] * ay[L-1:0];
      yll <= ay[L-1:0] * ay[L-1:0];
      rhh <= radius[R-1:RL] * radius[R-1:RL];
      rhl <= radius[R-1:RL] * radius[RL-1:0];
      rll <= radius[RL-1:0] * radius[RL-1:0];

      sqx <= (SQW'(xhh) << (2 * L)) + (SQW'(xhl) << (L + 1)) + SQW'(xll);
      sqy <= (SQW'(yhh) << (2 * L)) + (SQW'(yhl) << (L + 1)) + SQW'(yll);
      sqr <= (RSQ'(rhh) << (2 * RL)) + (RSQ'(rhl) << (RL + 1)) + RSQ'(rll);

      arrived <= ((SQW + 1)'(sqx) + (SQW + 1)'(sqy)) <= (SQW + 1)'(sqr);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gtg_checker.sv -----
`default_nettype none
module gtg_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [gtg_pkg::OUT_W-1:0]     m_tdata
);

  localparam int SW = gtg_pkg::SPEED_W;
  localparam int AW = gtg_pkg::ANGLE_WIDTH;

  a_arrived_stops: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[SW + AW] |-> m_tdata[SW + AW - 1:0] == '0)
    else $error("arrived beat with nonzero command");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind go_to_goal_steering gtg_checker u_gtg_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire
